// ===== src/assert_macros.svh =====
// assertion macros shared by the cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`endif

// ===== src/sawtc_pkg.sv =====
// shared types and codes of the set associative cache
package sawtc_pkg;
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_REFILL = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_READ_HIT  = 2'd0,
        ST_READ_MISS = 2'd1,
        ST_WRITE_FWD = 2'd2,
        ST_REFILL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_TAGRD,
        S_LOOK,
        S_DATRD,
        S_ACT,
        S_OUT
    } state_t;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[15:1]};
    endfunction
endpackage

// ===== src/set_assoc_write_through_cache.sv =====
// Set associative write-through cache, no write allocate, random replacement.
// Each item visits the tag memory and then the data memory one 8-byte word
// at a time: tag read, match, data read, update, then result register. Each
// further word or duplicate way written repeats data read and update, a second
// line repeats the pass from the tag read, and a read miss goes from match
// straight to the result register. Tags and data live in synchronous
// memories with separate read and write ports, each line's row read then
// written back. After reset the block runs a clearing pass over every set of
// the tag memory before it takes its first item. The input is ready again the
// cycle after the result register loads; while a held result waits for m_ready
// the next item can be taken and stalls only at its result register step.
module set_assoc_write_through_cache #(
    parameter int SETS       = 4096,
    parameter int WAYS       = 16,
    parameter int LINE_BYTES = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [31:0]              s_addr,
    input  logic [2:0]               s_size_bytes,
    input  logic [31:0]              s_write_data,
    input  logic [63:0]              s_fill_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [31:0]              m_read_data,
    output logic [31:0]              m_fetch_line_addr,
    output logic [31:0]              m_mem_write_addr,
    output logic [2:0]               m_mem_write_size,
    output logic [31:0]              m_mem_write_data
);
    import sawtc_pkg::*;
    `include "assert_macros.svh"

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W  = 32 - OFF_W - SET_W;
    localparam int WORDS  = (LINE_BYTES + 7) / 8;
    localparam int WRD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DADR_W = SET_W + WAY_W + WRD_W;
    localparam int BEAT_W = OFF_W - 3;

    state_t state_reg, state_next;

    // accepted item
    logic [1:0]  kind_reg;
    logic [31:0] addr_reg;
    logic [2:0]  len_reg;
    logic [31:0] wdata_reg;
    logic [63:0] fill_reg;
    // which line of the access (0 first, 1 second) and the read data gathered so far
    logic        part_reg;
    logic [31:0] rdata_reg;
    logic        miss_reg;
    logic [31:0] miss_addr_reg;
    logic [WAYS-1:0] hit_reg;
    logic [WAY_W-1:0] hitway_reg;
    logic [WAYS-1:0] vrow_reg;
    logic [WAYS*TAG_W-1:0] trow_reg;
    logic [15:0] lfsr_reg;
    logic [WAY_W-1:0] refill_way_reg;
    logic [SET_W-1:0] clr_reg;
    logic [WRD_W-1:0] word_reg;

    // result register
    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] o_rdata_reg, o_fetch_reg, o_waddr_reg, o_wdata_reg;
    logic [2:0]  o_wsize_reg;

    // byte addresses of the access
    logic [31:0] last_addr;
    logic [31:0] line_addr;
    logic        spans;
    logic [2:0]  len_in;

    assign len_in = (s_size_bytes >= 3'd1 && s_size_bytes <= 3'd4) ? s_size_bytes : 3'd4;
    assign last_addr = addr_reg + 32'(len_reg) - 32'd1;
    assign spans = (last_addr[31:OFF_W] != addr_reg[31:OFF_W]);
    assign line_addr = part_reg ? {last_addr[31:OFF_W], {OFF_W{1'b0}}}
                                : {addr_reg[31:OFF_W], {OFF_W{1'b0}}};

    logic [SET_W-1:0] cur_set;
    logic [TAG_W-1:0] cur_tag;
    assign cur_set = line_addr[OFF_W +: SET_W];
    assign cur_tag = line_addr[31 -: TAG_W];

    // byte positions 0..3 of the access that fall in the current line
    logic [3:0] in_line;
    logic [OFF_W-1:0] boff [4];
    always_comb begin
        logic [31:0] a;
        for (int i = 0; i < 4; i++) begin
            a = addr_reg + 32'(i);
            boff[i] = a[OFF_W-1:0];
            in_line[i] = (3'(i) < len_reg) && (a[31:OFF_W] == line_addr[31:OFF_W]);
        end
    end

    // tag memory
    logic [WAYS-1:0]       tv_q;
    logic [WAYS*TAG_W-1:0] tt_q;
    logic                  t_we;
    logic [SET_W-1:0]      t_wset, t_rset;
    logic [WAYS-1:0]       t_wv;
    logic [WAYS*TAG_W-1:0] t_wt;

    sawtc_tag_store #(.SET_W(SET_W), .WAYS(WAYS), .TAG_W(TAG_W)) u_tags (
        .aclk     (aclk),
        .rd_set   (t_rset),
        .rd_valid (tv_q),
        .rd_tags  (tt_q),
        .wr_en    (t_we),
        .wr_set   (t_wset),
        .wr_valid (t_wv),
        .wr_tags  (t_wt)
    );
    assign t_rset = cur_set;

    // hit compare
    logic [WAYS-1:0] hit_vec;
    logic [WAY_W-1:0] hit_first, inv_first;
    logic any_inv;
    always_comb begin
        hit_first = '0;
        inv_first = '0;
        any_inv = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = tv_q[w] && (tt_q[w*TAG_W +: TAG_W] == cur_tag);
            if (hit_vec[w]) hit_first = WAY_W'(w);
            if (!tv_q[w]) begin
                inv_first = WAY_W'(w);
                any_inv = 1'b1;
            end
        end
    end

    // data memory: 64-bit words; writes with duplicate ways sweep one way at a time
    logic [63:0] dmem [2**DADR_W];
    logic [63:0] d_q;
    logic        d_we;
    logic [DADR_W-1:0] d_radr, d_wadr;
    logic [63:0] d_wdata;
    logic [WAY_W-1:0] d_way;

    always_ff @(posedge aclk) begin
        if (d_we) begin
            dmem[d_wadr] <= d_wdata;
        end
        d_q <= dmem[d_radr];
    end

    // a read or write may touch two words of a line: handle one word at a time
    logic [WRD_W-1:0] first_word;
    logic             two_words;
    logic [WRD_W-1:0] last_word;
    always_comb begin
        first_word = '0;
        last_word = '0;
        for (int i = 3; i >= 0; i--) begin
            if (in_line[i]) first_word = WRD_W'(boff[i] >> 3);
        end
        for (int i = 0; i < 4; i++) begin
            if (in_line[i]) last_word = WRD_W'(boff[i] >> 3);
        end
        two_words = (first_word != last_word);
    end

    logic [BEAT_W-1:0] beat;
    assign beat = addr_reg[OFF_W-1:3];

    // pending ways to write for this word
    logic [WAYS-1:0] todo_reg;
    logic [WAY_W-1:0] todo_first;
    always_comb begin
        todo_first = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (todo_reg[w]) todo_first = WAY_W'(w);
        end
    end

    assign d_way = (kind_reg == KIND_REFILL) ? refill_way_reg
                 : (kind_reg == KIND_READ) ? hitway_reg : todo_first;
    assign d_radr = {cur_set, d_way, word_reg};

    // merged data word
    logic [63:0] merged;
    logic [31:0] rd_merge;
    always_comb begin
        merged = d_q;
        rd_merge = rdata_reg;
        for (int i = 0; i < 4; i++) begin
            if (in_line[i] && WRD_W'(boff[i] >> 3) == word_reg) begin
                merged[8*boff[i][2:0] +: 8] = wdata_reg[8*i +: 8];
                rd_merge[8*i +: 8] = d_q[8*boff[i][2:0] +: 8];
            end
        end
    end

    // refill victim and tag row update
    logic [WAY_W-1:0] victim;
    logic [15:0] lfsr_nx;
    assign lfsr_nx = lfsr_step(lfsr_reg);
    assign victim = any_inv ? inv_first : WAY_W'(lfsr_nx);

    logic last_beat;
    assign last_beat = (32'(beat) == 32'((LINE_BYTES - 1) / 8));

    // memory writes
    always_comb begin
        t_we = 1'b0;
        t_wset = cur_set;
        t_wv = vrow_reg;
        t_wt = trow_reg;
        d_we = 1'b0;
        d_wadr = d_radr;
        d_wdata = merged;
        if (state_reg == S_CLEAR) begin
            t_we = 1'b1;
            t_wset = clr_reg;
            t_wv = '0;
        end else if (state_reg == S_ACT && kind_reg == KIND_REFILL) begin
            t_we = 1'b1;
            // middle beats leave the valid bit as it stands
            if (last_beat) begin
                t_wv[refill_way_reg] = 1'b1;
                t_wt[refill_way_reg*TAG_W +: TAG_W] = cur_tag;
            end
            d_we = 1'b1;
            d_wadr = {cur_set, refill_way_reg, WRD_W'(beat)};
            d_wdata = fill_reg;
        end else if (state_reg == S_ACT && kind_reg == KIND_WRITE) begin
            d_we = |todo_reg;
        end
    end

    // next state
    logic word_done;
    assign word_done = (kind_reg == KIND_WRITE) ? ((todo_reg & ~(WAYS'(1) << todo_first)) == '0)
                                                : 1'b1;
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (32'(clr_reg) == 32'(SETS - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_valid && s_ready && s_kind != KIND_NONE) state_next = S_TAGRD;
            S_TAGRD: state_next = S_LOOK;
            S_LOOK: begin
                if (kind_reg == KIND_READ && hit_vec == '0) state_next = S_OUT;
                else state_next = S_DATRD;
            end
            S_DATRD: state_next = S_ACT;
            S_ACT: begin
                if (kind_reg == KIND_REFILL) state_next = S_OUT;
                else if (!word_done) state_next = S_DATRD;
                else if (two_words && word_reg != last_word) state_next = S_DATRD;
                else if (!part_reg && spans) state_next = S_TAGRD;
                else state_next = S_OUT;
            end
            S_OUT: if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            lfsr_reg <= LFSR_SEED;
            refill_way_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + SET_W'(1);
            if (state_reg == S_LOOK && kind_reg == KIND_REFILL && beat == '0) begin
                refill_way_reg <= victim;
                if (!any_inv) lfsr_reg <= lfsr_nx;
            end
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg <= s_kind;
            addr_reg <= s_addr;
            len_reg <= len_in;
            wdata_reg <= s_write_data;
            fill_reg <= s_fill_data;
            part_reg <= 1'b0;
            rdata_reg <= '0;
            miss_reg <= 1'b0;
            miss_addr_reg <= '0;
        end
        if (state_reg == S_LOOK) begin
            hit_reg <= hit_vec;
            hitway_reg <= hit_first;
            trow_reg <= tt_q;
            todo_reg <= hit_vec;
            if (kind_reg == KIND_REFILL && beat == '0) vrow_reg <= tv_q & ~(WAYS'(1) << victim);
            else vrow_reg <= tv_q;
            word_reg <= (kind_reg == KIND_REFILL) ? WRD_W'(beat) : first_word;
            if (kind_reg == KIND_READ && hit_vec == '0) begin
                miss_reg <= 1'b1;
                miss_addr_reg <= line_addr;
            end
        end
        if (state_reg == S_ACT) begin
            if (kind_reg == KIND_READ) rdata_reg <= rd_merge;
            if (kind_reg == KIND_WRITE && !word_done) begin
                todo_reg <= todo_reg & ~(WAYS'(1) << todo_first);
            end else if (two_words && word_reg != last_word) begin
                word_reg <= last_word;
                todo_reg <= hit_reg;
            end else if (!part_reg && spans) begin
                part_reg <= 1'b1;
            end
        end
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            o_rdata_reg <= '0;
            o_fetch_reg <= '0;
            o_waddr_reg <= '0;
            o_wsize_reg <= '0;
            o_wdata_reg <= '0;
            case (kind_reg)
                KIND_READ: begin
                    status_reg <= miss_reg ? ST_READ_MISS : ST_READ_HIT;
                    if (miss_reg) o_fetch_reg <= miss_addr_reg;
                    else o_rdata_reg <= rdata_reg;
                end
                KIND_WRITE: begin
                    status_reg <= ST_WRITE_FWD;
                    o_waddr_reg <= addr_reg;
                    o_wsize_reg <= len_reg;
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < len_reg) o_wdata_reg[8*i +: 8] <= wdata_reg[8*i +: 8];
                    end
                end
                default: status_reg <= ST_REFILL;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_read_data = o_rdata_reg;
    assign m_fetch_line_addr = o_fetch_reg;
    assign m_mem_write_addr = o_waddr_reg;
    assign m_mem_write_size = o_wsize_reg;
    assign m_mem_write_data = o_wdata_reg;

    `ASSERT_CLK(a_no_accept_busy, (s_valid && s_ready) |-> state_reg == S_IDLE, "accept while busy")
    `ASSERT_CLK(a_out_hold, (m_valid && !m_ready) |=> m_valid && $stable(m_status), "result dropped")
    `ASSERT_ALWAYS(a_clear_after_reset, !aresetn |=> state_reg == S_CLEAR, "no clear pass after reset")
endmodule

// ===== src/sawtc_tag_store.sv =====
// tag and valid memory: one row per set holding every way
module sawtc_tag_store #(
    parameter int SET_W = 12,
    parameter int WAYS  = 16,
    parameter int TAG_W = 14
) (
    input  logic                     aclk,
    input  logic [SET_W-1:0]         rd_set,
    output logic [WAYS-1:0]          rd_valid,
    output logic [WAYS*TAG_W-1:0]    rd_tags,
    input  logic                     wr_en,
    input  logic [SET_W-1:0]         wr_set,
    input  logic [WAYS-1:0]          wr_valid,
    input  logic [WAYS*TAG_W-1:0]    wr_tags
);
    logic [WAYS+WAYS*TAG_W-1:0] mem [2**SET_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_set] <= {wr_valid, wr_tags};
        end
        {rd_valid, rd_tags} <= mem[rd_set];
    end
endmodule

// ===== tb/tb_set_assoc_write_through_cache.sv =====
// testbench for the set associative write-through cache: random traffic checked against a predictor
module tb_set_assoc_write_through_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import sawtc_pkg::*;

    localparam int SETS       = 4096;
    localparam int WAYS       = 16;
    localparam int LINE_BYTES = 64;
    localparam int NUM_ITEMS  = 1500;

    typedef struct {
        kind_t       kind;
        logic [31:0] addr;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [63:0] fill;
        bit          drain;
    } access_t;

    typedef struct {
        status_t     status;
        logic [31:0] rdata;
        logic [31:0] fetch_addr;
        logic [31:0] wr_addr;
        logic [2:0]  wr_size;
        logic [31:0] wr_data;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = 2'd0;
    logic [31:0] s_addr = 32'd0;
    logic [2:0]  s_size_bytes = 3'd0;
    logic [31:0] s_write_data = 32'd0;
    logic [63:0] s_fill_data = 64'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_read_data;
    logic [31:0] m_fetch_line_addr;
    logic [31:0] m_mem_write_addr;
    logic [2:0]  m_mem_write_size;
    logic [31:0] m_mem_write_data;

    set_assoc_write_through_cache #(
        .SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES)
    ) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // cache shadow
    bit          line_vld [SETS*WAYS];
    logic [13:0] line_tagv[SETS*WAYS];
    logic [63:0] line_words[int];
    logic [15:0] victim_lfsr = LFSR_SEED;
    int          fill_way = 0;

    access_t     pending_q[$];
    response_t   expected_q[$];
    int          errors = 0;
    int          n_hits = 0, n_misses = 0, n_writes = 0, n_fills = 0;
    int          n_results = 0;

    function automatic int set_idx(logic [31:0] a);
        return int'(a[17:6]);
    endfunction

    function automatic logic [7:0] rd_byte(int line, int off);
        int key;
        key = line * 8 + off / 8;
        if (!line_words.exists(key)) return 8'h00;
        return line_words[key][(off % 8)*8 +: 8];
    endfunction

    function automatic void wr_byte(int line, int off, logic [7:0] v);
        int key;
        key = line * 8 + off / 8;
        if (!line_words.exists(key)) line_words[key] = 64'd0;
        line_words[key][(off % 8)*8 +: 8] = v;
    endfunction

    function automatic int find_way(logic [31:0] a);
        int base;
        base = set_idx(a) * WAYS;
        for (int w = 0; w < WAYS; w++)
            if (line_vld[base+w] && line_tagv[base+w] == a[31:18]) return w;
        return -1;
    endfunction

    function automatic int choose_victim(int set);
        logic b;
        for (int w = 0; w < WAYS; w++)
            if (!line_vld[set*WAYS+w]) return w;
        b = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
        victim_lfsr = {b, victim_lfsr[15:1]};
        return int'(victim_lfsr) % WAYS;
    endfunction

    // advance the shadow by one accepted item and queue its response
    function automatic void cache_step(access_t it);
        response_t r;
        int len, w, set, beat, line;
        logic [31:0] a;
        r = '{ST_READ_HIT, 32'd0, 32'd0, 32'd0, 3'd0, 32'd0};
        len = (it.size >= 1 && it.size <= 4) ? int'(it.size) : 4;
        case (it.kind)
            KIND_NONE: return;
            KIND_READ: begin
                for (int i = 0; i < len; i++) begin
                    a = it.addr + i;
                    w = find_way(a);
                    if (w < 0) begin
                        r.status = ST_READ_MISS;
                        r.fetch_addr = {a[31:6], 6'd0};
                        r.rdata = 32'd0;
                        break;
                    end
                    r.rdata[8*i +: 8] = rd_byte(set_idx(a)*WAYS + w, int'(a[5:0]));
                end
            end
            KIND_WRITE: begin
                for (int i = 0; i < len; i++) begin
                    a = it.addr + i;
                    for (int v = 0; v < WAYS; v++)
                        if (line_vld[set_idx(a)*WAYS+v] &&
                            line_tagv[set_idx(a)*WAYS+v] == a[31:18])
                            wr_byte(set_idx(a)*WAYS + v, int'(a[5:0]), it.wdata[8*i +: 8]);
                end
                r.status  = ST_WRITE_FWD;
                r.wr_addr = it.addr;
                r.wr_size = 3'(len);
                for (int i = 0; i < len; i++) r.wr_data[8*i +: 8] = it.wdata[8*i +: 8];
            end
            default: begin
                set  = set_idx(it.addr);
                beat = int'(it.addr[5:3]);
                if (beat == 0) begin
                    fill_way = choose_victim(set);
                    line_vld[set*WAYS + fill_way] = 1'b0;
                end
                line = set*WAYS + fill_way;
                for (int i = 0; i < 8; i++) wr_byte(line, beat*8 + i, it.fill[8*i +: 8]);
                if (beat == 7) begin
                    line_tagv[line] = it.addr[31:18];
                    line_vld[line]  = 1'b1;
                end
                r.status = ST_REFILL;
            end
        endcase
        expected_q.push_back(r);
    endfunction

    // driver
    int gap_cnt = 0;
    access_t cur;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) cache_step(cur);
            if (s_valid && !s_ready) begin
                // hold the item
            end else if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                s_valid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || expected_q.size() == 0)) begin
                cur = pending_q.pop_front();
                s_kind       <= cur.kind;
                s_addr       <= cur.addr;
                s_size_bytes <= cur.size;
                s_write_data <= cur.wdata;
                s_fill_data  <= cur.fill;
                s_valid      <= 1'b1;
                case ($urandom_range(0, 19))
                    0:             gap_cnt <= $urandom_range(10, 60);
                    1, 2, 3, 4, 5: gap_cnt <= $urandom_range(1, 3);
                    default:       gap_cnt <= 0;
                endcase
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic report(string fld, logic [63:0] e, logic [63:0] a);
        $display("%0t mismatch %s: expected %h actual %h", $realtime, fld, e, a);
        errors++;
    endtask

    // monitor and receiver stalls
    int hold_cnt = 0;
    bit long_hold_done = 0;
    always @(posedge aclk) begin
        response_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result status %0d", $realtime, m_status);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_status !== e.status) report("status", e.status, m_status);
                if (m_read_data !== e.rdata) report("read_data", e.rdata, m_read_data);
                if (m_fetch_line_addr !== e.fetch_addr)
                    report("fetch_line_addr", e.fetch_addr, m_fetch_line_addr);
                if (m_mem_write_addr !== e.wr_addr)
                    report("mem_write_addr", e.wr_addr, m_mem_write_addr);
                if (m_mem_write_size !== e.wr_size)
                    report("mem_write_size", e.wr_size, m_mem_write_size);
                if (m_mem_write_data !== e.wr_data)
                    report("mem_write_data", e.wr_data, m_mem_write_data);
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!long_hold_done && n_results == 400) begin
            // long stall so the input side backs up
            long_hold_done = 1;
            hold_cnt = 300;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (n_results > 800 && n_results < 1000) begin
            m_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 29))
                0:          hold_cnt = $urandom_range(15, 50);
                1, 2, 3, 4: hold_cnt = $urandom_range(1, 3);
                default:    hold_cnt = 0;
            endcase
            m_ready <= (hold_cnt == 0);
        end
    end

    // stimulus
    int n_pushed = 0;

    task automatic push(kind_t k, logic [31:0] a, logic [2:0] sz,
                        logic [31:0] wd, logic [63:0] fd, bit dr = 0);
        access_t it;
        it = '{k, a, sz, wd, fd, dr};
        pending_q.push_back(it);
        if (k != KIND_NONE) n_pushed++;
    endtask

    task automatic refill_line(logic [31:0] a);
        for (int b = 0; b < 8; b++)
            push(KIND_REFILL, {a[31:6], 3'(b), 3'($urandom_range(0, 7))}, 3'($urandom),
                 $urandom, {$urandom, $urandom});
    endtask

    function automatic logic [31:0] pick_addr();
        logic [13:0] tg;
        logic [11:0] st;
        logic [5:0]  off;
        case ($urandom_range(0, 9))
            0:       tg = 14'($urandom);
            1:       tg = 14'h3FFF - 14'($urandom_range(0, 3));
            default: tg = 14'($urandom_range(0, 19));
        endcase
        case ($urandom_range(0, 5))
            0:       st = 12'($urandom);
            1:       st = 12'hFFF;
            default: st = 12'($urandom_range(0, 2));
        endcase
        off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom);
        return {tg, st, off};
    endfunction

    function automatic logic [2:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 3'($urandom_range(5, 7));
            1: return 3'd0;
            2: return 3'd3;
            3, 4, 5: return 3'd1;
            6, 7, 8: return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    // read, fetch the lines it touches, read again, sometimes write and read back
    task automatic access_seq();
        logic [31:0] a;
        logic [2:0]  sz;
        int len;
        a = pick_addr();
        sz = pick_size();
        len = (sz >= 1 && sz <= 4) ? int'(sz) : 4;
        push(KIND_READ, a, sz, $urandom, {$urandom, $urandom});
        refill_line(a);
        if ((a[31:6]) != ((a + len - 1) >> 6)) refill_line(a + len - 1);
        push(KIND_READ, a, sz, $urandom, {$urandom, $urandom});
        if ($urandom_range(0, 1)) begin
            push(KIND_WRITE, a + $urandom_range(0, 2), pick_size(), $urandom,
                 {$urandom, $urandom});
            push(KIND_READ, a, sz, $urandom, {$urandom, $urandom});
        end
    endtask

    initial begin
        int next_drain;
        // directed: cold misses, address wrap, odd sizes, data extremes, unknown kind
        push(KIND_READ, 32'h0000_0000, 3'd4, 32'h0, 64'h0);
        push(KIND_READ, 32'hFFFF_FFFE, 3'd4, 32'h0, 64'h0);
        push(KIND_WRITE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        refill_line(32'hFFFF_FFC0);
        refill_line(32'h0000_0000);
        push(KIND_READ, 32'hFFFF_FFFE, 3'd0, 32'h0, 64'h0);
        push(KIND_NONE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push(KIND_WRITE, 32'h0000_003D, 3'd3, 32'hA5C3_7E18, 64'h0);
        push(KIND_WRITE, 32'h0000_0000, 3'd1, 32'hFFFF_FFFF, 64'h0);
        push(KIND_WRITE, 32'hFFFF_FFFF, 3'd2, 32'h0000_0000, 64'h0);
        push(KIND_READ, 32'hFFFF_FFFC, 3'd5, 32'h0, 64'h0, 1);
        push(KIND_READ, 32'h0000_003C, 3'd6, 32'h0, 64'h0);
        // same line fetched twice gives a duplicate tag
        refill_line(32'h0000_0000);
        push(KIND_WRITE, 32'h0000_0001, 3'd2, 32'h1234_5678, 64'h0);
        push(KIND_READ, 32'h0000_0000, 3'd4, 32'h0, 64'h0);

        next_drain = 200;
        while (n_pushed < NUM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1: push(KIND_READ, pick_addr(), pick_size(), $urandom, {$urandom, $urandom});
                2, 3: push(KIND_WRITE, pick_addr(), pick_size(), $urandom, {$urandom, $urandom});
                4:    push(KIND_NONE, $urandom, 3'($urandom), $urandom, {$urandom, $urandom});
                5:    refill_line(pick_addr());
                default: access_seq();
            endcase
            if (n_pushed >= next_drain) begin
                // pause until everything has drained
                push(KIND_READ, pick_addr(), pick_size(), $urandom, {$urandom, $urandom}, 1);
                next_drain += 300;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_q.size() == 0 && !s_valid && expected_q.size() == 0);
        repeat (50) @(posedge aclk);
        foreach (expected_q[i])
            $display("%0t missing result, expected status %0d", $realtime, expected_q[i].status);
        if (expected_q.size() != 0) errors++;
        $display("covered %0d items, %0d results checked, %0d mismatches",
                 n_pushed, n_results, errors);
        $display("reads, writes, refills, cold and wrapping lines, duplicate tags, stalls");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/sawtc_pkg.sv
src/sawtc_tag_store.sv
src/set_assoc_write_through_cache.sv
tb/tb_set_assoc_write_through_cache.sv
